FILE: rtl/pip_pkg.sv
package pip_pkg;

  localparam int MAX_VERTICES = 256;
  localparam int GRAB_RADIUS  = 4;
  localparam int IDX_W        = $clog2(MAX_VERTICES);
  localparam int CNT_W        = IDX_W + 1;

  // Vertex plus offset is 17 bits; differences are 18 bits.
  localparam int SUM_W  = 17;
  localparam int DIFF_W = 18;
  localparam int PROD_W = 2 * DIFF_W;

  // Quotient magnitude is bounded by the x difference (below 2^17).
  localparam int QMAG_W    = 17;
  localparam int DIV_STEPS = QMAG_W;
  localparam int STEP_W    = $clog2(DIV_STEPS + 1);

  localparam logic [2:0] REQ_CLEAR = 3'd0;
  localparam logic [2:0] REQ_ADD   = 3'd1;
  localparam logic [2:0] REQ_TEST  = 3'd2;
  localparam logic [2:0] REQ_GRAB  = 3'd3;
  localparam logic [2:0] REQ_DEL   = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  localparam logic CFG_OFFSET_X = 1'b0;
  localparam logic CFG_OFFSET_Y = 1'b1;

endpackage

FILE: rtl/pip_vertex_ram.sv
module pip_vertex_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 32,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/pip_divider.sv
module pip_divider (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic signed [pip_pkg::PROD_W-1:0] dividend,
  input  logic signed [pip_pkg::DIFF_W-1:0] divisor,
  output logic                              done,
  output logic signed [pip_pkg::DIFF_W-1:0] quotient
);
  import pip_pkg::*;

  logic              running;
  logic [STEP_W-1:0] step;
  logic [PROD_W-1:0] rem;
  logic [PROD_W-1:0] den;
  logic [QMAG_W-1:0] qmag;
  logic              neg;
  logic [PROD_W-1:0] trial;
  logic              fits;

  // divisor shifted to the current quotient bit
  assign trial = den << (step - STEP_W'(1));
  assign fits  = rem >= trial;

  // restoring division on magnitudes, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        step    <= STEP_W'(DIV_STEPS);
        rem     <= dividend[PROD_W-1] ? PROD_W'(-dividend) : PROD_W'(dividend);
        den     <= PROD_W'(divisor[DIFF_W-1] ? DIFF_W'(-divisor) : DIFF_W'(divisor));
        neg     <= dividend[PROD_W-1] ^ divisor[DIFF_W-1];
        qmag    <= '0;
      end else if (running) begin
        if (fits) begin
          rem <= rem - trial;
        end
        qmag <= {qmag[QMAG_W-2:0], fits};
        step <= step - STEP_W'(1);
        if (step == STEP_W'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  // truncation toward zero: negate the magnitude
  assign quotient = neg ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});

`ifndef SYNTHESIS
  a_done_after_run: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(running)) else $error("divider done without run");
  a_step_range: assert property (@(posedge clk) disable iff (rst)
    running |-> step != '0) else $error("divider step out of range");
  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    running && !start |=> !done || !running) else $error("divider overrun");
`endif

endmodule

FILE: rtl/polygon_point_hit_tester.sv
// Channel  | Signals                                        | Direction
// ---------+------------------------------------------------+----------
// request  | start, busy, req_type, coord_x, coord_y        | in; busy out
// config   | cfg_valid, cfg_ready, cfg_index, cfg_data      | in; cfg_ready out
// result   | done, inside_res, hit_found, hit_index,        | out
//          | vertex_count, status                           |
//
// Clear, add, delete and unused codes are handled in idle; done follows the next cycle.
// Grab reads one vertex per cycle from the vertex RAM until a hit or the last vertex.
// Point test: an edge walk over the vertices, plus for each edge that needs an
// intercept a multiply, then the bit-serial divider.
// Reset (rst, synchronous) empties the table and zeros offsets and box.
// The result strobe lasts one cycle; the receiver cannot stall it.
module polygon_point_hit_tester (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [2:0]                   req_type,
  input  logic signed [15:0]           coord_x,
  input  logic signed [15:0]           coord_y,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic                         cfg_index,
  input  logic [15:0]                  cfg_data,
  output logic                         done,
  output logic                         inside_res,
  output logic                         hit_found,
  output logic [pip_pkg::IDX_W-1:0]    hit_index,
  output logic [pip_pkg::CNT_W-1:0]    vertex_count,
  output logic [1:0]                   status
);
  import pip_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_TJ   = 6'b000010,
    S_TI   = 6'b000100,
    S_MUL  = 6'b001000,
    S_DIV  = 6'b010000,
    S_GR   = 6'b100000
  } state_t;

  state_t state;

  logic signed [15:0] offset_x, offset_y;
  logic signed [15:0] box_min_x, box_max_x, box_min_y, box_max_y;
  logic [CNT_W-1:0]   count;
  logic [IDX_W-1:0]   idx;
  logic signed [15:0] pt_x, pt_y;
  logic signed [SUM_W-1:0] xj, yj, xi_r;
  logic signed [DIFF_W-1:0] op_a, op_b, op_den;
  logic signed [PROD_W-1:0] prod;
  logic               parity;

  // vertex RAM ports
  logic               ram_we, ram_re;
  logic [IDX_W-1:0]   ram_raddr;
  logic [31:0]        ram_rdata;

  logic               accept;
  logic               last;
  logic               box_ok;
  logic signed [SUM_W-1:0] xi, yi, vx, vy, px_s, py_s;
  logic               crosses, near_ok;
  logic               div_start, div_done;
  logic signed [DIFF_W-1:0] quot;
  logic signed [SUM_W+1:0]  xcut;
  logic               grab_hit;

  assign accept       = start && !busy;
  assign busy         = state != S_IDLE;
  assign cfg_ready    = 1'b1;
  assign vertex_count = count;
  assign last         = {1'b0, idx} == count - CNT_W'(1);

  assign px_s = SUM_W'(pt_x);
  assign py_s = SUM_W'(pt_y);

  // strict box check on the offset box
  always_comb begin
    box_ok = (SUM_W'(box_min_x) + SUM_W'(offset_x) < SUM_W'(coord_x)) &&
             (SUM_W'(box_max_x) + SUM_W'(offset_x) > SUM_W'(coord_x)) &&
             (SUM_W'(box_min_y) + SUM_W'(offset_y) < SUM_W'(coord_y)) &&
             (SUM_W'(box_max_y) + SUM_W'(offset_y) > SUM_W'(coord_y));
  end

  // current vertex from RAM, raw and offset
  assign vx = SUM_W'($signed(ram_rdata[31:16]));
  assign vy = SUM_W'($signed(ram_rdata[15:0]));
  assign xi = vx + SUM_W'(offset_x);
  assign yi = vy + SUM_W'(offset_y);

  assign crosses = ((yi < py_s && yj >= py_s) || (yj < py_s && yi >= py_s)) &&
                   (xi <= px_s || xj <= px_s);

  assign near_ok = (px_s >= vx - SUM_W'(GRAB_RADIUS)) && (px_s < vx + SUM_W'(GRAB_RADIUS)) &&
                   (py_s >= vy - SUM_W'(GRAB_RADIUS)) && (py_s < vy + SUM_W'(GRAB_RADIUS));
  assign grab_hit = near_ok;

  assign xcut = (SUM_W+2)'(xi_r) + (SUM_W+2)'(quot);

  // intercept product from the registered operands, loaded by the divider in S_MUL
  assign prod = op_a * op_b;

  // RAM read address selection
  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = idx + IDX_W'(1);
    case (state)
      S_IDLE: begin
        if (accept && req_type == REQ_TEST) begin
          ram_re    = 1'b1;
          ram_raddr = IDX_W'(count - CNT_W'(1));
        end else if (accept && req_type == REQ_GRAB) begin
          ram_re    = 1'b1;
          ram_raddr = '0;
        end
      end
      S_TJ: begin
        ram_re    = 1'b1;
        ram_raddr = '0;
      end
      S_TI:    ram_re = !crosses && !last;
      S_DIV:   ram_re = div_done && !last;
      S_GR:    ram_re = !grab_hit && !last;
      default: ram_re = 1'b0;
    endcase
  end

  assign ram_we    = accept && req_type == REQ_ADD && count < CNT_W'(MAX_VERTICES);
  assign div_start = state == S_MUL;

  pip_vertex_ram #(.DEPTH(MAX_VERTICES), .WIDTH(32)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (IDX_W'(count)),
    .wdata ({coord_x, coord_y}),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  pip_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod),
    .divisor  (op_den),
    .done     (div_done),
    .quotient (quot)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      offset_x <= '0;
      offset_y <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_OFFSET_X: offset_x <= $signed(cfg_data);
        CFG_OFFSET_Y: offset_y <= $signed(cfg_data);
        default:      offset_x <= offset_x;
      endcase
    end
  end

  // request sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      done       <= 1'b0;
      box_min_x  <= '0;
      box_max_x  <= '0;
      box_min_y  <= '0;
      box_max_y  <= '0;
      inside_res <= 1'b0;
      hit_found  <= 1'b0;
      hit_index  <= '0;
      status     <= ST_OK;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            pt_x       <= coord_x;
            pt_y       <= coord_y;
            idx        <= '0;
            parity     <= 1'b0;
            inside_res <= 1'b0;
            hit_found  <= 1'b0;
            hit_index  <= '0;
            status     <= ST_OK;
            case (req_type)
              REQ_CLEAR: begin
                count <= '0;
                done  <= 1'b1;
              end
              REQ_ADD: begin
                done <= 1'b1;
                if (count >= CNT_W'(MAX_VERTICES)) begin
                  status <= ST_FULL;
                end else begin
                  count <= count + CNT_W'(1);
                  if (count == '0) begin
                    box_min_x <= coord_x;
                    box_max_x <= coord_x;
                    box_min_y <= coord_y;
                    box_max_y <= coord_y;
                  end else begin
                    if (coord_x > box_max_x) box_max_x <= coord_x;
                    else if (coord_x < box_min_x) box_min_x <= coord_x;
                    if (coord_y > box_max_y) box_max_y <= coord_y;
                    else if (coord_y < box_min_y) box_min_y <= coord_y;
                  end
                end
              end
              REQ_TEST: begin
                if (count != '0 && box_ok) state <= S_TJ;
                else done <= 1'b1;
              end
              REQ_GRAB: begin
                if (count != '0) state <= S_GR;
                else done <= 1'b1;
              end
              REQ_DEL: begin
                done <= 1'b1;
                if (count != '0) count <= count - CNT_W'(1);
                else status <= ST_EMPTY;
              end
              default: done <= 1'b1;
            endcase
          end
        end
        // closing vertex becomes the first j
        S_TJ: begin
          xj    <= xi;
          yj    <= yi;
          state <= S_TI;
        end
        S_TI: begin
          xj   <= xi;
          yj   <= yi;
          xi_r <= xi;
          if (crosses) begin
            op_a   <= DIFF_W'(py_s) - DIFF_W'(yi);
            op_b   <= DIFF_W'(xj) - DIFF_W'(xi);
            op_den <= DIFF_W'(yj) - DIFF_W'(yi);
            state  <= S_MUL;
          end else if (last) begin
            inside_res <= parity;
            done       <= 1'b1;
            state      <= S_IDLE;
          end else begin
            idx <= idx + IDX_W'(1);
          end
        end
        // divider loads the product at the end of this cycle
        S_MUL: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            if (xcut < (SUM_W+2)'(px_s)) begin
              parity <= !parity;
            end
            if (last) begin
              inside_res <= parity ^ (xcut < (SUM_W+2)'(px_s));
              done       <= 1'b1;
              state      <= S_IDLE;
            end else begin
              idx   <= idx + IDX_W'(1);
              state <= S_TI;
            end
          end
        end
        S_GR: begin
          if (grab_hit) begin
            hit_found <= 1'b1;
            hit_index <= idx;
            done      <= 1'b1;
            state     <= S_IDLE;
          end else if (last) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            idx <= idx + IDX_W'(1);
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("result while busy");
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_VERTICES)) else $error("count overflow");
  a_simple_one_cycle: assert property (@(posedge clk) disable iff (rst)
    accept && (req_type == REQ_ADD || req_type == REQ_DEL || req_type == REQ_CLEAR)
    |=> done) else $error("simple request without result");
  a_no_write_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !ram_we) else $error("RAM write during walk");
`endif

endmodule
